/* rtl/core/bce_pkg.sv */
`default_nettype none
package bce_pkg;

   localparam int FRAC_BITS = 16;
   localparam int IN_W      = FRAC_BITS + 1;
   localparam int LOSS_W    = 40;
   localparam int LOG_FBITS = 24;
   localparam int N_W       = 29;
   localparam int LN_W      = 21;
   localparam int ACC_W     = 40;
   localparam int DIV_W     = LOSS_W + 1;
   localparam int STEP_W    = 6;

   localparam logic [IN_W-1:0]   ONE_FX   = IN_W'(1) << FRAC_BITS;
   localparam logic [IN_W-1:0]   PRED_MAX = ONE_FX - IN_W'(1);
   localparam logic [31:0]       LN2_Q32  = 32'd2977044472;
   localparam logic [LOSS_W-1:0] LOSS_MAX = '1;

   localparam logic [1:0] MODE_MEAN = 2'd0;
   localparam logic [1:0] MODE_SUM  = 2'd1;
   localparam logic [1:0] MODE_NONE = 2'd2;

   localparam logic REG_REDUCTION_MODE = 1'b0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NORM,
      ST_SQUARE,
      ST_SCALE,
      ST_ROUND,
      ST_MAC1,
      ST_MAC2,
      ST_ACCUM,
      ST_DIV_LOAD,
      ST_DIVIDE,
      ST_EMIT
   } bce_state_type;

   typedef struct packed {
      logic load_item;
      logic log_load;
      logic log_sel_q;
      logic sq_step;
      logic scale;
      logic ln_store_p;
      logic ln_store_q;
      logic mac1;
      logic mac2;
      logic accum;
      logic div_load;
      logic div_step;
      logic emit;
   } bce_cmd_type;

   typedef struct packed {
      logic item_last;
      logic mode_sum;
      logic out_free;
   } bce_status_type;

endpackage
`default_nettype wire

/* rtl/core/bce_ctrl.sv */
`default_nettype none
module bce_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire bce_pkg::bce_status_type status,
   output bce_pkg::bce_cmd_type         cmd
);
   import bce_pkg::*;

   bce_state_type state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic which_ff, which_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         which_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         which_ff <= which_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      which_in  = which_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               which_in      = 1'b0;
               state_in      = ST_NORM;
            end
         end
         ST_NORM: begin
            cmd.log_load  = 1'b1;
            cmd.log_sel_q = which_ff;
            step_in       = '0;
            state_in      = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.sq_step = 1'b1;
            step_in     = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(LOG_FBITS - 1)) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_ROUND;
         end
         ST_ROUND: begin
            if (!which_ff) begin
               cmd.ln_store_p = 1'b1;
               which_in       = 1'b1;
               state_in       = ST_NORM;
            end else begin
               cmd.ln_store_q = 1'b1;
               state_in       = ST_MAC1;
            end
         end
         ST_MAC1: begin
            cmd.mac1 = 1'b1;
            state_in = ST_MAC2;
         end
         ST_MAC2: begin
            cmd.mac2 = 1'b1;
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
            if (!status.item_last) begin
               state_in = ST_IDLE;
            end else if (status.mode_sum) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_DIV_LOAD;
            end
         end
         ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            step_in      = '0;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_W - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // hold until the output register can take the beat
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

/* rtl/core/bce_datapath.sv */
`default_nettype none
module bce_datapath #(
   parameter int unsigned MAX_ELEMENTS_LOG2 = 20
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [bce_pkg::IN_W-1:0]     req_prediction,
   input  wire logic [bce_pkg::IN_W-1:0]     req_target,
   input  wire logic                         req_last,
   input  wire logic [1:0]                   reduction_mode,
   input  wire bce_pkg::bce_cmd_type         cmd,
   output bce_pkg::bce_status_type           status,
   input  wire logic                         rsp_stall,
   output logic                              rsp_valid,
   output logic [bce_pkg::LOSS_W-1:0]        rsp_loss,
   output logic                              rsp_label_error
);
   import bce_pkg::*;

   localparam int CW = MAX_ELEMENTS_LOG2 + 1;

   // item registers
   logic [FRAC_BITS-1:0] p_ff;
   logic [IN_W-1:0]      y_ff;
   logic                 last_ff;

   // log unit
   logic [31:0]          z_ff;
   logic [3:0]           m_ff;
   logic [LOG_FBITS-1:0] f_ff;
   logic [60:0]          scale_ff;
   logic [LN_W-1:0]      lp_ff, lq_ff;
   logic [ACC_W-1:0]     acc_ff;

   // batch state
   logic [LOSS_W-1:0]    sum_ff;
   logic [CW-1:0]        count_ff;
   logic                 bad_ff;

   // divider
   logic [CW-1:0]        rem_ff;
   logic [DIV_W-1:0]     quo_ff;

   // output register
   logic                 rsp_valid_ff;
   logic [LOSS_W-1:0]    loss_ff;
   logic                 label_error_ff;

   logic [FRAC_BITS-1:0] p_clip, log_x;
   logic [IN_W-1:0]      y_clip;
   logic                 bad_label;
   logic [3:0]           lz_m;
   logic [31:0]          x_wide, z_norm;
   logic [4:0]           norm_sh;
   logic [63:0]          sq_prod;
   logic [32:0]          sq_top;
   logic [N_W-1:0]       n_val;
   logic [60:0]          scale_rnd;
   logic [ACC_W-1:0]     elem_q;
   logic [LOSS_W:0]      sum_ext;
   logic [CW:0]          rem_sh;
   logic                 q_bit;
   logic [IN_W-1:0]      y_comp;

   always_comb begin
      if (req_prediction == '0) begin
         p_clip = FRAC_BITS'(1);
      end else if (req_prediction > PRED_MAX) begin
         p_clip = PRED_MAX[FRAC_BITS-1:0];
      end else begin
         p_clip = req_prediction[FRAC_BITS-1:0];
      end
      y_clip    = (req_target > ONE_FX) ? ONE_FX : req_target;
      bad_label = (req_target != '0) && (req_target != ONE_FX);
   end

   always_comb begin
      log_x = cmd.log_sel_q ? FRAC_BITS'(ONE_FX - {1'b0, p_ff}) : p_ff;
      lz_m  = '0;
      for (int i = 0; i < FRAC_BITS; i++) begin
         if (log_x[i]) lz_m = 4'(i);
      end
      norm_sh = 5'd31 - {1'b0, lz_m};
      x_wide  = {16'b0, log_x};
      z_norm  = x_wide << norm_sh;
   end

   assign sq_prod   = z_ff * z_ff;
   assign sq_top    = sq_prod[63:31];
   assign n_val     = {5'(FRAC_BITS) - {1'b0, m_ff}, 24'b0} - {5'b0, f_ff};
   assign scale_rnd = scale_ff + (61'(1) << 39);
   assign y_comp    = ONE_FX - y_ff;
   assign elem_q    = ACC_W'(acc_ff[ACC_W-1:FRAC_BITS]);
   assign sum_ext   = {1'b0, sum_ff} + {1'b0, elem_q};
   assign rem_sh    = {rem_ff, quo_ff[DIV_W-1]};
   assign q_bit     = rem_sh >= {1'b0, count_ff};

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         p_ff    <= p_clip;
         y_ff    <= y_clip;
         last_ff <= req_last;
      end
      if (cmd.log_load) begin
         z_ff <= z_norm;
         m_ff <= lz_m;
         f_ff <= '0;
      end else if (cmd.sq_step) begin
         z_ff <= sq_top[32] ? sq_top[32:1] : sq_top[31:0];
         f_ff <= {f_ff[LOG_FBITS-2:0], sq_top[32]};
      end
      if (cmd.scale) begin
         scale_ff <= 61'(n_val) * 61'(LN2_Q32);
      end
      if (cmd.ln_store_p) lp_ff <= scale_rnd[60:40];
      if (cmd.ln_store_q) lq_ff <= scale_rnd[60:40];
      if (cmd.mac1) begin
         acc_ff <= ACC_W'(y_ff * lp_ff);
      end else if (cmd.mac2) begin
         acc_ff <= acc_ff + ACC_W'(y_comp * lq_ff) + ACC_W'(ONE_FX >> 1);
      end
      if (cmd.div_load) begin
         rem_ff <= '0;
         quo_ff <= {1'b0, sum_ff} + DIV_W'(count_ff >> 1);
      end else if (cmd.div_step) begin
         rem_ff <= q_bit ? CW'(rem_sh - {1'b0, count_ff}) : rem_sh[CW-1:0];
         quo_ff <= {quo_ff[DIV_W-2:0], q_bit};
      end
      if (cmd.emit) begin
         loss_ff        <= (reduction_mode == MODE_SUM) ? sum_ff : quo_ff[LOSS_W-1:0];
         label_error_ff <= bad_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         count_ff     <= '0;
         bad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_item && bad_label) bad_ff <= 1'b1;
         if (cmd.accum) begin
            sum_ff <= (sum_ext >= {1'b0, LOSS_MAX}) ? LOSS_MAX : sum_ext[LOSS_W-1:0];
            if (count_ff != '1) count_ff <= count_ff + CW'(1);
         end
         if (cmd.emit) begin
            // drop the batch state once its result is latched
            sum_ff       <= '0;
            count_ff     <= '0;
            bad_ff       <= 1'b0;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.item_last = last_ff;
   assign status.mode_sum  = reduction_mode == MODE_SUM;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_loss        = loss_ff;
   assign rsp_label_error = label_error_ff;

endmodule
`default_nettype wire

/* rtl/core/binary_cross_entropy_loss_core.sv */
// Binary cross-entropy loss accumulator.
// Input channel (req_): one beat carries a prediction and a target, both
// unsigned Q1.16, and a last flag that closes the batch. The prediction is
// clipped to 1..65535 LSB; a target other than 0 or 1.0 sets label_error.
// Result channel (rsp_): one beat per batch, on the item marked last,
// carrying the Q24.16 loss (sum, or rounded mean) and the label flag.
// Both channels use valid/stall; the receiver drives stall.
// One item at a time: the two natural logs go through a shared
// squaring unit, each in turn (normalize, 24 squarings, scale, round),
// then a multiply-accumulate (mac1, mac2, accumulate); a new item is
// taken only once the block is back in idle. A last item in any mode but
// sum then runs the bit-serial divider (41 steps); in sum mode it goes
// on to emit. The result sits in an output register; while it is stalled
// the next batch keeps accumulating, and only the next emit waits.
// Reset clears the accumulator, the count, the label flag and the
// reduction mode (mean). reduction_mode is written over the APB port at
// byte address 0 and should be changed only while the block is idle.
`default_nettype none
module binary_cross_entropy_loss_core #(
   parameter int unsigned MAX_ELEMENTS_LOG2 = 20
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [bce_pkg::IN_W-1:0] req_prediction,
   input  wire logic [bce_pkg::IN_W-1:0] req_target,
   input  wire logic                     req_last,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [bce_pkg::LOSS_W-1:0]    rsp_loss,
   output logic                          rsp_label_error,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [2:0]               paddr,
   input  wire logic [31:0]              pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import bce_pkg::*;

   logic [1:0]     mode_ff;
   bce_cmd_type    cmd;
   bce_status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_MEAN;
      end else if (psel && penable && pwrite && paddr[2] == REG_REDUCTION_MODE) begin
         mode_ff <= pwdata[1:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_REDUCTION_MODE) ? {30'b0, mode_ff} : 32'b0;

   bce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bce_datapath #(
      .MAX_ELEMENTS_LOG2 (MAX_ELEMENTS_LOG2)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_prediction  (req_prediction),
      .req_target      (req_target),
      .req_last        (req_last),
      .reduction_mode  (mode_ff),
      .cmd             (cmd),
      .status          (status),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_loss        (rsp_loss),
      .rsp_label_error (rsp_label_error)
   );

endmodule
`default_nettype wire

/* rtl/core/bce_checker.sv */
`default_nettype none
module bce_protocol_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        req_last,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        pready
);

   // an accepted beat keeps the block busy for the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input accepted while previous item in flight");

   // a non-last beat cannot produce a result right away
   a_no_result_mid_batch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !req_last) |=> !$rose(rsp_valid))
      else $error("result appeared after non-last item");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result dropped while stalled");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("pready low");

endmodule

bind binary_cross_entropy_loss_core bce_protocol_checker u_bce_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_last  (req_last),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .pready    (pready)
);
`default_nettype wire

/* tb/sv/bce_checker.sv */
`default_nettype none
module bce_checker #(
   parameter int unsigned MAX_ELEMENTS_LOG2 = 20
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_stall,
   input  wire logic [bce_pkg::IN_W-1:0] req_prediction,
   input  wire logic [bce_pkg::IN_W-1:0] req_target,
   input  wire logic                     req_last,
   input  wire logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   input  wire logic [bce_pkg::LOSS_W-1:0] rsp_loss,
   input  wire logic                     rsp_label_error,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [2:0]               paddr,
   input  wire logic [31:0]              pwdata,
   input  wire logic                     pready,
   output int                            fail_count,
   output int                            pending_losses,
   output int                            batches_checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import bce_pkg::*;

   typedef struct {
      logic [LOSS_W-1:0] loss;
      logic              label_error;
   } batch_loss_type;

   localparam logic [63:0] COUNT_SAT = (64'd1 << (MAX_ELEMENTS_LOG2 + 1)) - 1;

   batch_loss_type    expected_losses[$];
   logic [LOSS_W-1:0] loss_acc;
   logic [63:0]       elem_count;
   logic              bad_label;
   logic [1:0]        reduce_mode;

   // -ln(x / 1.0) in Q.16 via log2 by repeated squaring, times ln 2
   function automatic logic [63:0] neg_ln_q16(logic [63:0] x);
      int          msb;
      logic [63:0] z;
      logic [63:0] f;
      logic [63:0] n;
      msb = 0;
      for (int b = 0; b < 40; b++)
         if (x[b]) msb = b;
      z = x << (31 - msb);
      f = '0;
      for (int i = 1; i <= LOG_FBITS; i++) begin
         z = (z * z) >> 31;
         if (z >= 64'h1_0000_0000) begin
            f[LOG_FBITS - i] = 1'b1;
            z = z >> 1;
         end
      end
      n = (64'(FRAC_BITS - msb) << LOG_FBITS) - f;
      return (n * 64'(LN2_Q32) + (64'd1 << (55 - FRAC_BITS))) >> (56 - FRAC_BITS);
   endfunction

   task automatic accumulate_item(logic [IN_W-1:0] pred, logic [IN_W-1:0] tgt,
                                  logic last);
      logic [63:0] p;
      logic [63:0] y;
      logic [63:0] elem;
      logic [63:0] reduced;
      batch_loss_type res;
      p = 64'(pred);
      y = 64'(tgt);
      if (y != 0 && y != 64'(ONE_FX)) bad_label = 1'b1;
      if (y > 64'(ONE_FX)) y = 64'(ONE_FX);
      if (p < 1) p = 1;
      if (p > 64'(PRED_MAX)) p = 64'(PRED_MAX);
      elem = (y * neg_ln_q16(p) + (64'(ONE_FX) - y) * neg_ln_q16(64'(ONE_FX) - p)
              + (64'(ONE_FX) >> 1)) >> FRAC_BITS;
      if (elem >= 64'(LOSS_MAX) - 64'(loss_acc)) loss_acc = LOSS_MAX;
      else loss_acc = loss_acc + LOSS_W'(elem);
      if (elem_count < COUNT_SAT) elem_count++;
      if (last) begin
         if (reduce_mode == MODE_SUM) reduced = 64'(loss_acc);
         else reduced = (64'(loss_acc) + (elem_count >> 1)) / elem_count;
         res.loss        = LOSS_W'(reduced);
         res.label_error = bad_label;
         expected_losses.push_back(res);
         loss_acc   = '0;
         elem_count = '0;
         bad_label  = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      batch_loss_type want;
      if (reset) begin
         expected_losses.delete();
         loss_acc        = '0;
         elem_count      = '0;
         bad_label       = 1'b0;
         reduce_mode     = MODE_MEAN;
         fail_count      = 0;
         pending_losses  = 0;
         batches_checked = 0;
      end else begin
         if (psel && penable && pwrite && pready && paddr[2] == REG_REDUCTION_MODE)
            reduce_mode = pwdata[1:0];
         if (req_valid && !req_stall)
            accumulate_item(req_prediction, req_target, req_last);
         if (rsp_valid && !rsp_stall) begin
            if (expected_losses.size() == 0) begin
               $error("unexpected result beat: loss %0d label_error %0d",
                      rsp_loss, rsp_label_error);
               fail_count = fail_count + 1;
            end else begin
               want = expected_losses.pop_front();
               batches_checked = batches_checked + 1;
               if (rsp_loss !== want.loss) begin
                  $error("loss: expected %0d, actual %0d", want.loss, rsp_loss);
                  fail_count = fail_count + 1;
               end
               if (rsp_label_error !== want.label_error) begin
                  $error("label_error: expected %0d, actual %0d",
                         want.label_error, rsp_label_error);
                  fail_count = fail_count + 1;
               end
            end
         end
         pending_losses = expected_losses.size();
      end
   end
endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import bce_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int         STALL_LIMIT = 4000;
   localparam int         ITEM_TARGET = 900;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [IN_W-1:0]   req_prediction;
   logic [IN_W-1:0]   req_target;
   logic              req_last;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [LOSS_W-1:0] rsp_loss;
   logic              rsp_label_error;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [2:0]        paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;
   int                fail_count;
   int                pending_losses;
   int                batches_checked;
   int                send_idle_pct;
   int                recv_stall_pct;
   int                items_sent;
   int                quiet_cycles;

   binary_cross_entropy_loss_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_prediction(req_prediction), .req_target(req_target), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_loss(rsp_loss), .rsp_label_error(rsp_label_error),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   bce_checker loss_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_prediction(req_prediction), .req_target(req_target), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_loss(rsp_loss), .rsp_label_error(rsp_label_error),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready),
      .fail_count(fail_count), .pending_losses(pending_losses),
      .batches_checked(batches_checked)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("binary_cross_entropy_loss_core: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_pair(logic [IN_W-1:0] pred, logic [IN_W-1:0] tgt, logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_prediction <= pred;
      req_target     <= tgt;
      req_last       <= last;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // hold off until every batch result is back, then let the divider settle
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_losses != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [IN_W-1:0] pick_prediction();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         case ($urandom_range(0, 3))
            0: return '0;
            1: return IN_W'(1);
            2: return PRED_MAX;
            default: return ONE_FX;
         endcase
      end
      if (r == 1) return IN_W'($urandom_range(0, 131071));
      return IN_W'($urandom_range(0, 65536));
   endfunction

   function automatic logic [IN_W-1:0] pick_target();
      int r;
      r = $urandom_range(0, 19);
      if (r < 18) return $urandom_range(0, 1) ? ONE_FX : '0;
      if (r == 18) return IN_W'($urandom_range(0, 131071));
      return IN_W'($urandom_range(1, 65535));
   endfunction

   initial begin
      logic [1:0] mode_seq[4];
      int         batch_len;
      int         batches;
      int         mode_pick;
      mode_seq       = '{MODE_SUM, MODE_NONE, MODE_UNUSED, MODE_MEAN};
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_prediction = '0;
      req_target     = '0;
      req_last       = 1'b0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      items_sent     = 0;
      batches        = 0;
      mode_pick      = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: clip edges, bad labels, every mode
      csr_write(3'd0, 32'(MODE_MEAN));
      send_pair('0, '0, 1'b0);
      send_pair(IN_W'(1), ONE_FX, 1'b0);
      send_pair(PRED_MAX, '0, 1'b0);
      send_pair(ONE_FX, ONE_FX, 1'b1);
      drain_results();
      csr_write(3'd0, 32'(MODE_SUM));
      send_pair('1, '1, 1'b1);
      send_pair(IN_W'(32768), IN_W'(32768), 1'b1);
      send_pair(PRED_MAX, ONE_FX, 1'b1);
      send_pair(IN_W'(1), '0, 1'b0);
      send_pair(IN_W'(1), ONE_FX, 1'b1);
      drain_results();
      csr_write(3'd0, 32'(MODE_NONE));
      send_pair(IN_W'(12345), IN_W'(1), 1'b0);
      send_pair(IN_W'(54321), '0, 1'b1);
      drain_results();
      csr_write(3'd0, 32'hFFFF_FFFF);
      send_pair(IN_W'(40000), ONE_FX, 1'b1);
      drain_results();
      // writes to an unmapped register must not disturb the mode
      csr_write(3'd4, 32'(MODE_SUM));
      send_pair(IN_W'(20000), '0, 1'b0);
      send_pair(IN_W'(50000), ONE_FX, 1'b1);
      drain_results();

      while (items_sent < ITEM_TARGET) begin
         if (items_sent < 320) begin
            send_idle_pct  = 12;
            recv_stall_pct = 54;
         end else if (items_sent < 620) begin
            send_idle_pct  = 54;
            recv_stall_pct = 12;
         end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         batch_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                 : $urandom_range(1, 8);
         for (int i = 1; i <= batch_len; i++)
            send_pair(pick_prediction(), pick_target(), i == batch_len);
         batches++;
         if (batches % 10 == 0) begin
            drain_results();
            csr_write(3'd0, 32'(mode_seq[mode_pick % 4]) | 32'($urandom) << 2);
            mode_pick++;
         end
      end

      drain_results();
      $display("covered %0d pairs in %0d checked batches across all reduction modes,",
               items_sent, batches_checked);
      $display("with clip and bad-label edges and sender/receiver gaps");
      if (fail_count == 0 && pending_losses == 0) begin
         $display("binary_cross_entropy_loss_core: match");
      end else begin
         $display("binary_cross_entropy_loss_core: mismatch");
      end
      $finish;
   end
endmodule
`default_nettype wire

/* filelist.f */
rtl/core/bce_pkg.sv
rtl/core/bce_ctrl.sv
rtl/core/bce_datapath.sv
rtl/core/binary_cross_entropy_loss_core.sv
rtl/core/bce_checker.sv
tb/sv/bce_checker.sv
tb/sv/testbench.sv
